// File: design/srph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srph_pkg: shared definitions for the swept RSSI peak hold
// Action codes, level limits, display scaling helpers and the result bundle.
// ----------------------------------------------------------------------------
package srph_pkg;

   localparam int BIN_COUNT_DEF = 32;

   // Action codes carried on the request channel
   localparam logic [1:0] ACT_SAMPLE      = 2'd0;
   localparam logic [1:0] ACT_CLEAR_PEAKS = 2'd1;
   localparam logic [1:0] ACT_CLEAR_ALL   = 2'd2;

   // Level limits in dBm
   localparam int FLOOR_DBM = -130;
   localparam int CEIL_DBM  = -30;
   localparam int LEVEL_MIN = -127;
   localparam int LEVEL_MAX = 0;

   // Colour class thresholds, strongest first
   localparam int COLOUR_T0 = -50;
   localparam int COLOUR_T1 = -65;
   localparam int COLOUR_T2 = -80;
   localparam int COLOUR_T3 = -95;
   localparam int COLOUR_T4 = -110;
   localparam int COLOUR_T5 = -122;

   // Chart scale: 80 steps over a 100 dB span, i.e. times 4 then divide by 5
   localparam int CHART_TOP    = 270;
   localparam int CHART_BOTTOM = 350;
   localparam int BAR_MIN      = 2;
   // Divide by 5 as (y * 205) >> 10, exact for y up to 400
   localparam int DIV5_RECIP   = 205;
   localparam int DIV5_SHIFT   = 10;

   typedef struct packed {
      logic [4:0]         bin_index;
      logic signed [7:0]  level_dbm;
      logic signed [7:0]  bin_peak_dbm;
      logic [2:0]         color_class;
      logic [6:0]         bar_height;
      logic [6:0]         peak_height;
      logic signed [7:0]  strongest_dbm;
      logic [4:0]         strongest_bin;
      logic               sweep_done;
      logic [31:0]        sweep_total;
      logic [4:0]         next_bin;
   } rsp_type;

   function automatic logic [2:0] colour_of(input logic signed [7:0] r);
      logic [2:0] c;
      if (r > COLOUR_T0) begin
         c = 3'd0;
      end else if (r > COLOUR_T1) begin
         c = 3'd1;
      end else if (r > COLOUR_T2) begin
         c = 3'd2;
      end else if (r > COLOUR_T3) begin
         c = 3'd3;
      end else if (r > COLOUR_T4) begin
         c = 3'd4;
      end else if (r > COLOUR_T5) begin
         c = 3'd5;
      end else begin
         c = 3'd6;
      end
      return c;
   endfunction

   function automatic logic [6:0] height_of(input logic signed [7:0] r);
      int          rc;
      logic [6:0]  off;
      logic [8:0]  y;
      logic [16:0] prod;
      rc = int'(r);
      if (rc < FLOOR_DBM) rc = FLOOR_DBM;
      if (rc > CEIL_DBM)  rc = CEIL_DBM;
      off  = 7'(rc - FLOOR_DBM);                 // 0..100
      y    = {off, 2'b00};                       // times 4
      prod = 17'(y) * 17'(DIV5_RECIP);
      return prod[DIV5_SHIFT +: 7];              // divide by 5
   endfunction

endpackage

// File: design/swept_rssi_peak_hold_top.sv
`timescale 1ns / 1ps
// Results: only a sample produces a result, registered in the output register or the skid stage.
// Throughput: one transaction per cycle; req_stall rises only when the output
//   register and the skid stage both hold undelivered results.
// Reset: synchronous; all peaks read as -130, strongest entry -127 at bin 0,
//   bin counter and sweep count zero, output empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// swept_rssi_peak_hold_top: per-bin peak hold over a repeating RSSI sweep
// Clamps each sample, raises its bin's peak, tracks the strongest level,
// steps the bin counter, emits display classes and bar heights, and clears on request.
// ----------------------------------------------------------------------------
module swept_rssi_peak_hold_top #(
   parameter int BIN_COUNT = srph_pkg::BIN_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [8:0]  req_sample_dbm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_bin_index,
   output logic signed [7:0]  rsp_level_dbm,
   output logic signed [7:0]  rsp_bin_peak_dbm,
   output logic [2:0]         rsp_color_class,
   output logic [6:0]         rsp_bar_height,
   output logic [6:0]         rsp_peak_height,
   output logic signed [7:0]  rsp_strongest_dbm,
   output logic [4:0]         rsp_strongest_bin,
   output logic               rsp_sweep_done,
   output logic [31:0]        rsp_sweep_total,
   output logic [4:0]         rsp_next_bin
);
   import srph_pkg::*;

   localparam int BIN_W = $clog2(BIN_COUNT);

   // Sweep position and strongest entry
   logic [BIN_W-1:0]     cur_bin_ff, cur_bin_in;
   logic [31:0]          sweep_ff, sweep_in;
   logic signed [7:0]    str_lvl_ff, str_lvl_in;
   logic [BIN_W-1:0]     str_bin_ff, str_bin_in;

   // Peak store: one valid bit per bin, invalid bins read as the floor
   logic [BIN_COUNT-1:0] valid_ff, valid_in;
   logic [7:0]           peak_mem [BIN_COUNT];
   logic [7:0]           rd_ff;

   // Output register and skid stage
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_type              out_ff, out_in;
   rsp_type              skid_ff, skid_in;

   logic                 accept;
   logic                 wr_en;
   logic                 last_bin;
   logic signed [7:0]    level;
   logic signed [8:0]    peak_old;
   logic signed [7:0]    peak_new;
   logic                 str_raise;
   logic [7:0]           bar_raw;
   rsp_type              res;

   // Hold the input whenever the skid stage is occupied
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req_action == ACT_SAMPLE);
   assign last_bin  = (cur_bin_ff == BIN_W'(BIN_COUNT - 1));

   // Clamp the sample to the reporting range
   always_comb begin
      if (req_sample_dbm > 9'(LEVEL_MAX)) begin
         level = 8'(LEVEL_MAX);
      end else if (req_sample_dbm < 9'(LEVEL_MIN)) begin
         level = 8'(LEVEL_MIN);
      end else begin
         level = req_sample_dbm[7:0];
      end
   end

   // The read register always holds the entry of the current bin: it is
   // reloaded each cycle from the bin the counter is about to hold, and that
   // bin never equals the one being written in the same cycle.
   assign peak_old  = valid_ff[cur_bin_ff] ? {rd_ff[7], rd_ff} : 9'(FLOOR_DBM);
   assign peak_new  = ($signed({level[7], level}) > peak_old) ? level : peak_old[7:0];
   assign str_raise = (level > str_lvl_ff);

   // Next state of the sweep, the strongest entry and the peak valid bits
   always_comb begin
      cur_bin_in = cur_bin_ff;
      sweep_in   = sweep_ff;
      str_lvl_in = str_lvl_ff;
      str_bin_in = str_bin_ff;
      valid_in   = valid_ff;
      if (accept) begin
         case (req_action)
            ACT_SAMPLE: begin
               valid_in[cur_bin_ff] = 1'b1;
               if (str_raise) begin
                  str_lvl_in = level;
                  str_bin_in = cur_bin_ff;
               end
               if (last_bin) begin
                  cur_bin_in = '0;
                  sweep_in   = sweep_ff + 32'd1;
               end else begin
                  cur_bin_in = cur_bin_ff + 1'b1;
               end
            end
            ACT_CLEAR_PEAKS: begin
               valid_in   = '0;
               str_lvl_in = 8'(LEVEL_MIN);
               str_bin_in = '0;
            end
            ACT_CLEAR_ALL: begin
               valid_in   = '0;
               str_lvl_in = 8'(LEVEL_MIN);
               str_bin_in = '0;
               cur_bin_in = '0;
               sweep_in   = '0;
            end
            default: begin
               // undefined action: drop it, nothing changes
            end
         endcase
      end
   end

   // Assemble the result of a sample
   assign bar_raw = 8'(height_of(level));
   always_comb begin
      res.bin_index     = 5'(cur_bin_ff);
      res.level_dbm     = level;
      res.bin_peak_dbm  = peak_new;
      res.color_class   = colour_of(level);
      res.bar_height    = (bar_raw < 8'(BAR_MIN)) ? 7'(BAR_MIN) : bar_raw[6:0];
      res.peak_height   = height_of(peak_new);
      res.strongest_dbm = str_lvl_in;
      res.strongest_bin = 5'(str_bin_in);
      res.sweep_done    = last_bin;
      res.sweep_total   = sweep_in;
      res.next_bin      = 5'(cur_bin_in);
   end

   // Output register and skid: results leave in order, oldest first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && !out_valid_in) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (wr_en) begin
         if (!out_valid_in) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bin_ff    <= '0;
         sweep_ff      <= '0;
         str_lvl_ff    <= 8'(LEVEL_MIN);
         str_bin_ff    <= '0;
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cur_bin_ff    <= cur_bin_in;
         sweep_ff      <= sweep_in;
         str_lvl_ff    <= str_lvl_in;
         str_bin_ff    <= str_bin_in;
         valid_ff      <= valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Peak store: write the raised peak, prefetch the next bin's entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         peak_mem[cur_bin_ff] <= peak_new;
      end
      rd_ff <= peak_mem[cur_bin_in];
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_bin_index     = out_ff.bin_index;
   assign rsp_level_dbm     = out_ff.level_dbm;
   assign rsp_bin_peak_dbm  = out_ff.bin_peak_dbm;
   assign rsp_color_class   = out_ff.color_class;
   assign rsp_bar_height    = out_ff.bar_height;
   assign rsp_peak_height   = out_ff.peak_height;
   assign rsp_strongest_dbm = out_ff.strongest_dbm;
   assign rsp_strongest_bin = out_ff.strongest_bin;
   assign rsp_sweep_done    = out_ff.sweep_done;
   assign rsp_sweep_total   = out_ff.sweep_total;
   assign rsp_next_bin      = out_ff.next_bin;

endmodule
